>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/r30_pkg.sv
// Shared constants, types and the generation function for the rule 30 random bit source.
package r30_pkg;

    localparam int CELLS    = 256;
    localparam int MID_CELL = CELLS / 2;
    localparam int CNT_W    = 20;
    localparam int ACC_W    = 32;
    localparam int SEED_W   = 32;
    localparam int BITS_W   = 6;

    localparam logic [CNT_W:0] SEED_MOD = (CNT_W + 1)'(20'hFFFFF);

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic is_draw;
    } t_stat;

    // One rule 30 generation over the circular row.
    function automatic logic [CELLS-1:0] next_gen(input logic [CELLS-1:0] row);
        logic [CELLS-1:0] left;
        logic [CELLS-1:0] right;
        left  = {row[CELLS-2:0], row[CELLS-1]};
        right = {row[0], row[CELLS-1:1]};
        return left ^ (row | right);
    endfunction

endpackage

>>> hdl/r30_dpath.sv
// Datapath: cell row, generation counter, bit accumulator and output register.
module r30_dpath import r30_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_opcode,
    input  logic [SEED_W-1:0] i_seed_value,
    input  logic [BITS_W-1:0] i_bit_count,
    output t_stat             o_stat,
    output logic [ACC_W-1:0]  o_random_value
);

    logic [CELLS-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_draw, n_draw;
    logic [ACC_W-1:0] r_out, n_out;

    logic [CELLS-1:0] gen_row;
    logic [CNT_W:0]   seed_sum;
    logic [CNT_W:0]   seed_red;

    // 2^20 is 1 modulo 0xFFFFF, so fold the upper bits onto the lower ones.
    assign seed_sum = (CNT_W + 1)'(i_seed_value[SEED_W-1:CNT_W])
                    + (CNT_W + 1)'(i_seed_value[CNT_W-1:0]);
    assign seed_red = (seed_sum >= SEED_MOD) ? (seed_sum - SEED_MOD) : seed_sum;
    assign gen_row  = next_gen(r_row);

    always_comb begin
        n_row  = r_row;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_draw = r_draw;
        n_out  = r_out;
        if (i_cmd.load) begin
            n_draw = i_opcode;
            if (i_opcode == OP_SEED) begin
                n_row           = '0;
                n_row[MID_CELL] = 1'b1;
                n_cnt           = seed_red[CNT_W-1:0];
            end else begin
                n_cnt = CNT_W'(i_bit_count);
                n_acc = '0;
            end
        end else if (i_cmd.step) begin
            n_row = gen_row;
            n_cnt = r_cnt - CNT_W'(1);
            if (r_draw == OP_DRAW) begin
                n_acc = {r_acc[ACC_W-2:0], gen_row[MID_CELL]};
            end
        end
        if (i_cmd.push) begin
            n_out = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_cnt  <= '0;
            r_draw <= OP_SEED;
        end else begin
            r_row  <= n_row;
            r_cnt  <= n_cnt;
            r_draw <= n_draw;
        end
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.is_draw  = (r_draw == OP_DRAW);
    assign o_random_value  = r_out;

endmodule

>>> hdl/r30_ctrl.sv
// Controller: sequences seed and draw transactions and owns the output valid flag.
module r30_ctrl import r30_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.cnt_zero) begin
                    n_state = i_stat.is_draw ? ST_DONE : ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/rule30_ca_random_bits.sv
// Rule 30 random bit source: a circular row of CELLS cells, one generation per clock while
// a transaction runs. A seed transaction (tuser = 0) resets the row to a single set middle cell,
// advances it (seed mod 0xFFFFF) generations and gives no result. A draw transaction (tuser = 1)
// advances the row bit_count generations and gives one 32-bit result, newest middle-cell bit in
// bit 0. A single generation step works on the whole row register; one transaction is
// worked at a time, and a new one is accepted while a previous result waits in the output register.
module rule30_ca_random_bits import r30_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // seed_value[31:0], bit_count[37:32], zero pad
    input  logic        i_s_axis_tuser,  // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // random_value[31:0]
);

    t_cmd  cmd;
    t_stat stat;

    r30_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    r30_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_s_axis_tuser),
        .i_seed_value   (i_s_axis_tdata[SEED_W-1:0]),
        .i_bit_count    (i_s_axis_tdata[SEED_W+BITS_W-1:SEED_W]),
        .o_stat         (stat),
        .o_random_value (o_m_axis_tdata)
    );

endmodule

>>> hdl/r30_checker.sv
// Port-level checker for the rule 30 random bit source, bound to the top level.
`include "assert_macros.svh"

module r30_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // one transaction at a time: input closes after an accept
    `ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, in_acc, !o_s_axis_tready)
    // no result appears the cycle right after an accept
    `ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, in_acc, !$rose(o_m_axis_tvalid))
    // a new result comes only out of a busy period
    `ASSERT_SAME(a_result_from_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(!o_s_axis_tready))

endmodule

bind rule30_ca_random_bits r30_checker u_r30_checker (.*);
